FILE: design/imm_pkg.sv
// imm_pkg: shared types, codes and sizes for the integer matrix multiplier
// used by imm_front, imm_back, imm_outq and integer_matrix_multiply

package imm_pkg;

    localparam int DIM_DEFAULT = 8;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [1:0] MODE_WRITE_A  = 2'd0;
    localparam logic [1:0] MODE_WRITE_B  = 2'd1;
    localparam logic [1:0] MODE_MULTIPLY = 2'd2;

    localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [1:0] CFG_COL_COUNT   = 2'd2;

    localparam logic [3:0] COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        KIND_WR_A,
        KIND_WR_B,
        KIND_MUL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
    } t_result;

endpackage

FILE: design/imm_front.sv
// imm_front: accepts input beats, drops ignored ones, queues commands
// depends on imm_pkg

module imm_front #(
    parameter int DIM = imm_pkg::DIM_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic [31:0]        i_elem_value,
    output logic               o_cmd_valid,
    output imm_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_pop
);

    imm_pkg::t_cmd r_q [imm_pkg::CMDQ_DEPTH];
    logic [imm_pkg::CMDQ_PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [imm_pkg::CMDQ_CW-1:0] r_count;

    logic          keep;
    logic          in_range;
    imm_pkg::t_cmd cmd_in;
    logic          do_push, do_pop;

    assign in_range = (32'(i_row_index) < DIM) && (32'(i_col_index) < DIM);

    always_comb begin
        cmd_in.row   = i_row_index;
        cmd_in.col   = i_col_index;
        cmd_in.value = i_elem_value;
        cmd_in.kind  = imm_pkg::KIND_MUL;
        keep         = 1'b0;
        unique case (i_mode)
            imm_pkg::MODE_WRITE_A: begin
                cmd_in.kind = imm_pkg::KIND_WR_A;
                keep        = in_range;
            end
            imm_pkg::MODE_WRITE_B: begin
                cmd_in.kind = imm_pkg::KIND_WR_B;
                keep        = in_range;
            end
            imm_pkg::MODE_MULTIPLY: begin
                cmd_in.kind = imm_pkg::KIND_MUL;
                keep        = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign full        = (r_count == imm_pkg::CMDQ_CW'(imm_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign do_push     = push && !full && keep;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == imm_pkg::CMDQ_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == imm_pkg::CMDQ_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/imm_outq.sv
// imm_outq: small result queue between the multiply engine and the output
// depends on imm_pkg

module imm_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  imm_pkg::t_result            i_data,
    output logic [imm_pkg::OUTQ_CW-1:0] o_count,
    output logic                        empty,
    input  logic                        pop,
    output imm_pkg::t_result            o_data
);

    imm_pkg::t_result r_q [imm_pkg::OUTQ_DEPTH];
    logic [imm_pkg::OUTQ_PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [imm_pkg::OUTQ_CW-1:0] r_count;
    logic do_pop;

    assign empty   = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_q[r_rd_ptr];
    assign do_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == imm_pkg::OUTQ_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == imm_pkg::OUTQ_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/imm_back.sv
// imm_back: matrix stores, element sequencer and pipelined multiply-accumulate
// depends on imm_pkg; feeds imm_outq with credit against its fill level

module imm_back #(
    parameter int DIM = imm_pkg::DIM_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  imm_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    input  logic [3:0]                  i_row_count,
    input  logic [3:0]                  i_inner_count,
    input  logic [3:0]                  i_col_count,
    input  logic [imm_pkg::OUTQ_CW-1:0] i_outq_count,
    output logic                        o_res_push,
    output imm_pkg::t_result            o_res
);

    localparam int IW = $clog2(DIM);
    localparam int AW = $clog2(DIM * DIM);
    localparam int CW = $clog2(DIM + 1);

    typedef enum logic {
        ST_IDLE,
        ST_MUL
    } t_state;

    typedef struct packed {
        logic          first;
        logic          endel;
        logic          zero;
        logic          lastall;
        logic [IW-1:0] row;
        logic [IW-1:0] col;
    } t_tag;

    logic [31:0] mem_a [DIM * DIM];
    logic [31:0] mem_b [DIM * DIM];
    logic [31:0] r_a_q, r_b_q;

    t_state r_state;
    logic [IW-1:0] r_i, r_k, r_j;
    logic [CW-1:0] r_m, r_n, r_p;
    logic [imm_pkg::OUTQ_CW-1:0] r_inflight;
    logic r_s1_v, r_s2_v;
    t_tag r_s1, r_s2;
    logic [31:0] r_prod, r_acc;

    logic [CW-1:0] m_c, n_c, p_c;
    logic [IW-1:0] nlast;
    logic endel, lastcol, lastrow;
    logic can_issue, issue;
    logic wr_a, wr_b;
    logic [AW-1:0] wr_addr, addr_a, addr_b;
    logic [31:0] sum;
    t_tag tag_in;

    assign m_c = (32'(i_row_count) > DIM)   ? CW'(DIM) : CW'(i_row_count);
    assign n_c = (32'(i_inner_count) > DIM) ? CW'(DIM) : CW'(i_inner_count);
    assign p_c = (32'(i_col_count) > DIM)   ? CW'(DIM) : CW'(i_col_count);

    assign nlast   = (r_n == '0) ? '0 : IW'(r_n - CW'(1));
    assign endel   = (r_j == nlast);
    assign lastcol = (r_k == IW'(r_p - CW'(1)));
    assign lastrow = (r_i == IW'(r_m - CW'(1)));

    // a new element starts only if the result queue keeps a slot for it
    assign can_issue = (r_j != '0) ||
                       (32'(r_inflight) + 32'(i_outq_count) < imm_pkg::OUTQ_DEPTH);
    assign issue     = (r_state == ST_MUL) && can_issue;

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign wr_a      = o_cmd_pop && (i_cmd.kind == imm_pkg::KIND_WR_A);
    assign wr_b      = o_cmd_pop && (i_cmd.kind == imm_pkg::KIND_WR_B);
    assign wr_addr   = AW'(IW'(i_cmd.row)) * AW'(DIM) + AW'(IW'(i_cmd.col));
    assign addr_a    = AW'(r_i) * AW'(DIM) + AW'(r_j);
    assign addr_b    = AW'(r_j) * AW'(DIM) + AW'(r_k);

    always_comb begin
        tag_in.first   = (r_j == '0);
        tag_in.endel   = endel;
        tag_in.zero    = (r_n == '0);
        tag_in.lastall = endel && lastcol && lastrow;
        tag_in.row     = r_i;
        tag_in.col     = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[wr_addr] <= i_cmd.value;
        end
        r_a_q <= mem_a[addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[wr_addr] <= i_cmd.value;
        end
        r_b_q <= mem_b[addr_b];
    end

    assign sum        = r_s2.first ? r_prod : r_acc + r_prod;
    assign o_res_push = r_s2_v && r_s2.endel;

    always_comb begin
        o_res.row   = 3'(r_s2.row);
        o_res.col   = 3'(r_s2.col);
        o_res.value = sum;
        o_res.last  = r_s2.lastall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_inflight <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;

            if (issue && tag_in.first && !o_res_push) begin
                r_inflight <= r_inflight + 1'b1;
            end else if (!(issue && tag_in.first) && o_res_push) begin
                r_inflight <= r_inflight - 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop && (i_cmd.kind == imm_pkg::KIND_MUL) &&
                        (m_c != '0) && (p_c != '0)) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (issue && endel && lastcol && lastrow) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_m <= m_c;
            r_n <= n_c;
            r_p <= p_c;
            r_i <= '0;
            r_k <= '0;
            r_j <= '0;
        end else if (issue) begin
            if (endel) begin
                r_j <= '0;
                if (lastcol) begin
                    r_k <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end else begin
                r_j <= r_j + 1'b1;
            end
        end

        if (issue) begin
            r_s1 <= tag_in;
        end
        r_s2   <= r_s1;
        r_prod <= r_s1.zero ? 32'd0 : r_a_q * r_b_q;
        if (r_s2_v) begin
            r_acc <= sum;
        end
    end

endmodule

FILE: design/integer_matrix_multiply.sv
// integer_matrix_multiply: top level, configuration registers and wiring
// depends on imm_pkg, imm_front, imm_back, imm_outq
//
//  channel   handshake                 beat contents
//  input     push / full               i_mode, i_row_index, i_col_index, i_elem_value
//  result    empty / pop               o_out_row, o_out_col, o_product_value, o_last
//  config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// a store write is written as the engine takes it; a multiply issues
// rows * cols * max(inner, 1) products through the operand and product registers
// into the accumulator, one multiply-accumulate unit reading one A and one B word
// per cycle unless issue holds; reset clears the queues and sets all counts to 8;
// store contents are not reset; a 2-deep command queue parts input from the engine
// and a 4-deep result queue parts the engine from the output; issue holds at an
// element start while the result queue has no free slot

module integer_matrix_multiply #(
    parameter int DIM = imm_pkg::DIM_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic signed [31:0] i_elem_value,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_out_row,
    output logic [2:0]         o_out_col,
    output logic signed [31:0] o_product_value,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    logic [3:0] r_row_count, r_inner_count, r_col_count;

    logic                        cmd_valid, cmd_pop;
    imm_pkg::t_cmd               cmd;
    logic [imm_pkg::OUTQ_CW-1:0] outq_count;
    logic                        res_push;
    imm_pkg::t_result            res_in, res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= imm_pkg::COUNT_RESET;
            r_inner_count <= imm_pkg::COUNT_RESET;
            r_col_count   <= imm_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                imm_pkg::CFG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                imm_pkg::CFG_INNER_COUNT: r_inner_count <= i_cfg_data;
                imm_pkg::CFG_COL_COUNT:   r_col_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    imm_front #(
        .DIM (DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    imm_back #(
        .DIM (DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_row_count   (r_row_count),
        .i_inner_count (r_inner_count),
        .i_col_count   (r_col_count),
        .i_outq_count  (outq_count),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    imm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_count (outq_count),
        .empty   (empty),
        .pop     (pop),
        .o_data  (res_out)
    );

    assign o_out_row       = res_out.row;
    assign o_out_col       = res_out.col;
    assign o_product_value = res_out.value;
    assign o_last          = res_out.last;

endmodule
